@@ src/skl_pkg.sv @@
// skl_pkg: widths, types and status codes shared by the closest points pipeline
`default_nettype none
package skl_pkg;

  localparam int CW  = 24;       // input coordinate width
  localparam int OW  = 32;       // output coordinate width
  localparam int DFW = CW + 1;   // point difference
  localparam int PW  = 2 * DFW;  // product of two differences
  localparam int VW  = 52;       // cross product component
  localparam int HW  = VW / 2;   // half of a cross component
  localparam int SW  = 2 * VW;   // dot product of cross components
  localparam int XW  = 130;      // difference times dot product
  localparam int RW  = 134;      // divider remainder
  localparam int QW  = 33;       // quotient magnitude bits

  localparam int FRONT_LAT = 6;
  localparam int SCALE_LAT = 3;
  localparam int DIV_LAT   = QW + 1;
  localparam int MID_LAT   = SCALE_LAT + DIV_LAT;
  localparam int LAT       = FRONT_LAT + MID_LAT + 1;

  typedef logic signed [CW-1:0] crd_t;
  typedef logic signed [DFW-1:0] dif_t;
  typedef logic signed [PW-1:0] prd_t;
  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [SW-1:0] dot_t;
  typedef logic signed [XW-1:0] xw_t;
  typedef logic [RW-1:0] rem_t;
  typedef logic signed [QW+2:0] pv_t;
  typedef logic signed [OW-1:0] ov_t;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK  = 2'd0;
  localparam status_t ST_DEG = 2'd1;
  localparam status_t ST_SAT = 2'd2;

  localparam ov_t OMAX = {1'b0, {(OW-1){1'b1}}};
  localparam ov_t OMIN = {1'b1, {(OW-1){1'b0}}};

  typedef struct packed {
    dif_t [2:0] d1;
    dif_t [2:0] d2;
    crd_t [2:0] a;
    crd_t [2:0] c;
  } side_t;

  typedef struct packed {
    logic  vld;
    dot_t  den;
    dot_t  num1;
    dot_t  num2;
    side_t sd;
  } front_t;

  typedef struct packed {
    logic       deg;
    crd_t [2:0] a;
    crd_t [2:0] c;
  } mid_t;

  typedef struct packed {
    logic sat;
    ov_t  v;
  } res_t;

endpackage
`default_nettype wire

@@ src/skew_line_closest_points_core.sv @@
// skew_line_closest_points_core: closest points between two 3D lines, top level
`default_nettype none
// Takes one request per clock. Behind the cross and dot product stages, each of the six rounding
// dividers runs a 33 stage quotient pipeline. busy is high only during reset. The receiver cannot
// stall: out_valid is high for one cycle per request and the result must be taken then. Parallel or
// degenerate lines give status 1 with the input points; clamped results give status 2.
module skew_line_closest_points_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  skl_pkg::crd_t        in_a_x,
  input  skl_pkg::crd_t        in_a_y,
  input  skl_pkg::crd_t        in_a_z,
  input  skl_pkg::crd_t        in_b_x,
  input  skl_pkg::crd_t        in_b_y,
  input  skl_pkg::crd_t        in_b_z,
  input  skl_pkg::crd_t        in_c_x,
  input  skl_pkg::crd_t        in_c_y,
  input  skl_pkg::crd_t        in_c_z,
  input  skl_pkg::crd_t        in_d_x,
  input  skl_pkg::crd_t        in_d_y,
  input  skl_pkg::crd_t        in_d_z,
  output logic                 out_valid,
  output skl_pkg::ov_t         out_p1_x,
  output skl_pkg::ov_t         out_p1_y,
  output skl_pkg::ov_t         out_p1_z,
  output skl_pkg::ov_t         out_p2_x,
  output skl_pkg::ov_t         out_p2_y,
  output skl_pkg::ov_t         out_p2_z,
  output skl_pkg::status_t     out_status
);

  function automatic skl_pkg::res_t fin(input skl_pkg::crd_t base,
                                        input logic [skl_pkg::QW-1:0] q,
                                        input logic neg, input logic ov);
    skl_pkg::pv_t   qs, pv;
    skl_pkg::res_t  r;
    qs = neg ? -skl_pkg::pv_t'({1'b0, q}) : skl_pkg::pv_t'({1'b0, q});
    pv = skl_pkg::pv_t'(base) - qs;
    r.sat = 1'b1;
    if (ov) begin
      r.v = neg ? skl_pkg::OMAX : skl_pkg::OMIN;
    end else if (pv > skl_pkg::pv_t'(skl_pkg::OMAX)) begin
      r.v = skl_pkg::OMAX;
    end else if (pv < skl_pkg::pv_t'(skl_pkg::OMIN)) begin
      r.v = skl_pkg::OMIN;
    end else begin
      r.v   = pv[skl_pkg::OW-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  skl_pkg::crd_t [2:0] pa, pb, pc, pd;
  skl_pkg::front_t     fr;
  logic                acc;
  logic                mv_r [1:skl_pkg::MID_LAT];
  skl_pkg::mid_t       md_r [1:skl_pkg::MID_LAT];
  logic [skl_pkg::QW-1:0] q [0:5];
  logic                qneg [0:5];
  logic                qov  [0:5];
  skl_pkg::res_t       res  [0:5];
  skl_pkg::mid_t       mo;
  logic                any_sat;
  logic                out_valid_r;
  skl_pkg::ov_t        p_r [0:5];
  skl_pkg::status_t    status_r, status_nxt;

  assign busy = ~rst_n;
  assign acc  = start & ~busy;
  assign pa   = {in_a_z, in_a_y, in_a_x};
  assign pb   = {in_b_z, in_b_y, in_b_x};
  assign pc   = {in_c_z, in_c_y, in_c_x};
  assign pd   = {in_d_z, in_d_y, in_d_x};

  skl_front u_front (
    .clk(clk), .rst_n(rst_n), .in_vld(acc),
    .in_a(pa), .in_b(pb), .in_c(pc), .in_d(pd), .fr(fr)
  );

  for (genvar g = 0; g < 6; g++) begin : g_lane
    skl_pkg::dif_t ld;
    skl_pkg::dot_t lnum;
    skl_pkg::rem_t lnr, ldv;
    logic          lneg;
    if (g < 3) begin : g_p1
      assign ld   = fr.sd.d1[g];
      assign lnum = fr.num1;
    end else begin : g_p2
      assign ld   = fr.sd.d2[g-3];
      assign lnum = fr.num2;
    end
    skl_scale u_scale (
      .clk(clk), .d(ld), .num(lnum), .den(fr.den), .nr(lnr), .dv(ldv), .neg(lneg)
    );
    skl_div u_div (
      .clk(clk), .nr(lnr), .dv(ldv), .neg(lneg), .q(q[g]), .qneg(qneg[g]), .ov(qov[g])
    );
  end

  // points and degenerate flag ride alongside the dividers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= skl_pkg::MID_LAT; k++) mv_r[k] <= 1'b0;
    end else begin
      mv_r[1] <= fr.vld;
      for (int k = 2; k <= skl_pkg::MID_LAT; k++) mv_r[k] <= mv_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    md_r[1].deg <= (fr.den == '0);
    md_r[1].a   <= fr.sd.a;
    md_r[1].c   <= fr.sd.c;
    for (int k = 2; k <= skl_pkg::MID_LAT; k++) md_r[k] <= md_r[k-1];
  end

  assign mo = md_r[skl_pkg::MID_LAT];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i]   = fin(mo.a[i], q[i], qneg[i], qov[i]);
      res[i+3] = fin(mo.c[i], q[i+3], qneg[i+3], qov[i+3]);
    end
    any_sat = 1'b0;
    for (int i = 0; i < 6; i++) any_sat = any_sat | res[i].sat;
    if (mo.deg) begin
      status_nxt = skl_pkg::ST_DEG;
    end else if (any_sat) begin
      status_nxt = skl_pkg::ST_SAT;
    end else begin
      status_nxt = skl_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= mv_r[skl_pkg::MID_LAT];
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    for (int i = 0; i < 3; i++) begin
      p_r[i]   <= mo.deg ? skl_pkg::ov_t'(mo.a[i]) : res[i].v;
      p_r[i+3] <= mo.deg ? skl_pkg::ov_t'(mo.c[i]) : res[i+3].v;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_p1_x   = p_r[0];
  assign out_p1_y   = p_r[1];
  assign out_p1_z   = p_r[2];
  assign out_p2_x   = p_r[3];
  assign out_p2_y   = p_r[4];
  assign out_p2_z   = p_r[5];
  assign out_status = status_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(skl_pkg::LAT) out_valid)
    else $error("request did not produce a result at the pipeline latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, skl_pkg::LAT))
    else $error("result without a matching request");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == skl_pkg::ST_SAT) |->
      (out_p1_x == skl_pkg::OMAX || out_p1_x == skl_pkg::OMIN ||
       out_p1_y == skl_pkg::OMAX || out_p1_y == skl_pkg::OMIN ||
       out_p1_z == skl_pkg::OMAX || out_p1_z == skl_pkg::OMIN ||
       out_p2_x == skl_pkg::OMAX || out_p2_x == skl_pkg::OMIN ||
       out_p2_y == skl_pkg::OMAX || out_p2_y == skl_pkg::OMIN ||
       out_p2_z == skl_pkg::OMAX || out_p2_z == skl_pkg::OMIN))
    else $error("saturated status without a clamped coordinate");

endmodule
`default_nettype wire

@@ src/skl_wmul.sv @@
// skl_wmul: two stage signed multiplier for cross product components
`default_nettype none
module skl_wmul (
  input  logic          clk,
  input  skl_pkg::vec_t a,
  input  skl_pkg::vec_t b,
  output skl_pkg::dot_t p
);

  logic signed [skl_pkg::HW-1:0] ah, bh;
  logic signed [skl_pkg::HW:0] al, bl;
  logic signed [2*skl_pkg::HW-1:0] hh_r;
  logic signed [2*skl_pkg::HW:0] hl_r, lh_r;
  logic signed [2*skl_pkg::HW+1:0] ll_r;
  skl_pkg::dot_t p_r;

  assign ah = a[skl_pkg::VW-1:skl_pkg::HW];
  assign bh = b[skl_pkg::VW-1:skl_pkg::HW];
  assign al = $signed({1'b0, a[skl_pkg::HW-1:0]});
  assign bl = $signed({1'b0, b[skl_pkg::HW-1:0]});

  always_ff @(posedge clk) begin
    hh_r <= ah * bh;
    hl_r <= ah * bl;
    lh_r <= al * bh;
    ll_r <= al * bl;
    p_r  <= (skl_pkg::dot_t'(hh_r) <<< (2 * skl_pkg::HW))
          + (skl_pkg::dot_t'(hl_r) <<< skl_pkg::HW)
          + (skl_pkg::dot_t'(lh_r) <<< skl_pkg::HW)
          + skl_pkg::dot_t'(ll_r);
  end

  assign p = p_r;

endmodule
`default_nettype wire

@@ src/skl_front.sv @@
// skl_front: direction vectors, cross products and the dot products of the solve
`default_nettype none
module skl_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  skl_pkg::crd_t [2:0]   in_a,
  input  skl_pkg::crd_t [2:0]   in_b,
  input  skl_pkg::crd_t [2:0]   in_c,
  input  skl_pkg::crd_t [2:0]   in_d,
  output skl_pkg::front_t       fr
);

  logic               vld_r [1:skl_pkg::FRONT_LAT];
  skl_pkg::side_t     sd_r  [1:skl_pkg::FRONT_LAT];
  skl_pkg::dif_t [2:0] w_r;
  skl_pkg::prd_t      pn_r  [0:5];
  skl_pkg::prd_t      pt1_r [0:5];
  skl_pkg::prd_t      pt2_r [0:5];
  skl_pkg::vec_t      n_r   [0:2];
  skl_pkg::vec_t      t1_r  [0:2];
  skl_pkg::vec_t      t2_r  [0:2];
  skl_pkg::dot_t      sq    [0:2];
  skl_pkg::dot_t      m1    [0:2];
  skl_pkg::dot_t      m2    [0:2];
  skl_pkg::dot_t      den_r, num1_r, num2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= skl_pkg::FRONT_LAT; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[1] <= in_vld;
      for (int k = 2; k <= skl_pkg::FRONT_LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sd_r[1].d1[i] <= skl_pkg::dif_t'(in_b[i]) - skl_pkg::dif_t'(in_a[i]);
      sd_r[1].d2[i] <= skl_pkg::dif_t'(in_d[i]) - skl_pkg::dif_t'(in_c[i]);
      w_r[i]        <= skl_pkg::dif_t'(in_a[i]) - skl_pkg::dif_t'(in_c[i]);
    end
    sd_r[1].a <= in_a;
    sd_r[1].c <= in_c;
    for (int k = 2; k <= skl_pkg::FRONT_LAT; k++) sd_r[k] <= sd_r[k-1];
  end

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    always_ff @(posedge clk) begin
      pn_r[2*i]    <= $signed(sd_r[1].d1[J]) * $signed(sd_r[1].d2[K]);
      pn_r[2*i+1]  <= $signed(sd_r[1].d1[K]) * $signed(sd_r[1].d2[J]);
      pt1_r[2*i]   <= $signed(w_r[J]) * $signed(sd_r[1].d1[K]);
      pt1_r[2*i+1] <= $signed(w_r[K]) * $signed(sd_r[1].d1[J]);
      pt2_r[2*i]   <= $signed(w_r[J]) * $signed(sd_r[1].d2[K]);
      pt2_r[2*i+1] <= $signed(w_r[K]) * $signed(sd_r[1].d2[J]);
      n_r[i]  <= skl_pkg::vec_t'(pn_r[2*i]) - skl_pkg::vec_t'(pn_r[2*i+1]);
      t1_r[i] <= skl_pkg::vec_t'(pt1_r[2*i]) - skl_pkg::vec_t'(pt1_r[2*i+1]);
      t2_r[i] <= skl_pkg::vec_t'(pt2_r[2*i]) - skl_pkg::vec_t'(pt2_r[2*i+1]);
    end

    skl_wmul u_sq (.clk(clk), .a(n_r[i]), .b(n_r[i]),  .p(sq[i]));
    skl_wmul u_m1 (.clk(clk), .a(n_r[i]), .b(t1_r[i]), .p(m1[i]));
    skl_wmul u_m2 (.clk(clk), .a(n_r[i]), .b(t2_r[i]), .p(m2[i]));
  end

  always_ff @(posedge clk) begin
    den_r  <= sq[0] + sq[1] + sq[2];
    num1_r <= m2[0] + m2[1] + m2[2];
    num2_r <= m1[0] + m1[1] + m1[2];
  end

  assign fr.vld  = vld_r[skl_pkg::FRONT_LAT];
  assign fr.den  = den_r;
  assign fr.num1 = num1_r;
  assign fr.num2 = num2_r;
  assign fr.sd   = sd_r[skl_pkg::FRONT_LAT];

endmodule
`default_nettype wire

@@ src/skl_scale.sv @@
// skl_scale: scales one direction component and forms the rounded divide operands
`default_nettype none
module skl_scale (
  input  logic          clk,
  input  skl_pkg::dif_t d,
  input  skl_pkg::dot_t num,
  input  skl_pkg::dot_t den,
  output skl_pkg::rem_t nr,
  output skl_pkg::rem_t dv,
  output logic          neg
);

  logic signed [2*skl_pkg::HW-1:0] pp_r [0:3];
  skl_pkg::dot_t den1_r, den2_r;
  skl_pkg::xw_t  x_r;
  logic [skl_pkg::XW-1:0] ax;
  skl_pkg::rem_t nr_r, dv_r;
  logic neg_r;

  assign ax = x_r[skl_pkg::XW-1] ? -x_r : x_r;

  always_ff @(posedge clk) begin
    pp_r[0] <= d * $signed({1'b0, num[skl_pkg::HW-1:0]});
    pp_r[1] <= d * $signed({1'b0, num[2*skl_pkg::HW-1:skl_pkg::HW]});
    pp_r[2] <= d * $signed({1'b0, num[3*skl_pkg::HW-1:2*skl_pkg::HW]});
    pp_r[3] <= d * $signed(num[skl_pkg::SW-1:3*skl_pkg::HW]);
    den1_r  <= den;
    x_r <= skl_pkg::xw_t'(pp_r[0])
         + (skl_pkg::xw_t'(pp_r[1]) <<< skl_pkg::HW)
         + (skl_pkg::xw_t'(pp_r[2]) <<< (2 * skl_pkg::HW))
         + (skl_pkg::xw_t'(pp_r[3]) <<< (3 * skl_pkg::HW));
    den2_r <= den1_r;
    neg_r  <= x_r[skl_pkg::XW-1];
    nr_r   <= skl_pkg::rem_t'({ax, 1'b0}) + skl_pkg::rem_t'(den2_r[skl_pkg::SW-1:0]);
    dv_r   <= skl_pkg::rem_t'({den2_r[skl_pkg::SW-1:0], 1'b0});
  end

  assign nr  = nr_r;
  assign dv  = dv_r;
  assign neg = neg_r;

endmodule
`default_nettype wire

@@ src/skl_div.sv @@
// skl_div: pipelined restoring divider, one quotient bit per stage, with overflow flag
`default_nettype none
module skl_div (
  input  logic                   clk,
  input  skl_pkg::rem_t          nr,
  input  skl_pkg::rem_t          dv,
  input  logic                   neg,
  output logic [skl_pkg::QW-1:0] q,
  output logic                   qneg,
  output logic                   ov
);

  skl_pkg::rem_t          rem_r [0:skl_pkg::QW];
  skl_pkg::rem_t          dv_r  [0:skl_pkg::QW];
  logic [skl_pkg::QW-1:0] q_r   [0:skl_pkg::QW];
  logic                   neg_r [0:skl_pkg::QW];
  logic                   ov_r  [0:skl_pkg::QW];

  always_ff @(posedge clk) begin
    rem_r[0] <= nr;
    dv_r[0]  <= dv;
    q_r[0]   <= '0;
    neg_r[0] <= neg;
    ov_r[0]  <= (nr >= (dv << skl_pkg::QW));
  end

  for (genvar s = 1; s <= skl_pkg::QW; s++) begin : g_stage
    localparam int B = skl_pkg::QW - s;
    skl_pkg::rem_t dsh;
    logic          take;
    assign dsh  = dv_r[s-1] << B;
    assign take = (rem_r[s-1] >= dsh);
    always_ff @(posedge clk) begin
      rem_r[s] <= take ? (rem_r[s-1] - dsh) : rem_r[s-1];
      q_r[s]   <= {q_r[s-1][skl_pkg::QW-2:0], take};
      dv_r[s]  <= dv_r[s-1];
      neg_r[s] <= neg_r[s-1];
      ov_r[s]  <= ov_r[s-1];
    end
  end

  assign q    = q_r[skl_pkg::QW];
  assign qneg = neg_r[skl_pkg::QW];
  assign ov   = ov_r[skl_pkg::QW];

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// testbench: self-checking bench for the skew line closest points core
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic                 drain;
    skl_pkg::crd_t [11:0] v;
  } line_pair_t;

  typedef struct packed {
    skl_pkg::ov_t [5:0] p;
    skl_pkg::status_t   st;
  } closest_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  skl_pkg::crd_t in_v [12];
  logic out_valid;
  skl_pkg::ov_t out_p [6];
  skl_pkg::status_t out_status;

  line_pair_t pending_pairs[$];
  closest_t closest_q[$];
  line_pair_t cur_pair;
  int sent_cnt;
  int mismatch_cnt;
  int stall_cnt;

  skew_line_closest_points_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_x(in_v[0]), .in_a_y(in_v[1]), .in_a_z(in_v[2]),
    .in_b_x(in_v[3]), .in_b_y(in_v[4]), .in_b_z(in_v[5]),
    .in_c_x(in_v[6]), .in_c_y(in_v[7]), .in_c_z(in_v[8]),
    .in_d_x(in_v[9]), .in_d_y(in_v[10]), .in_d_z(in_v[11]),
    .out_valid(out_valid),
    .out_p1_x(out_p[0]), .out_p1_y(out_p[1]), .out_p1_z(out_p[2]),
    .out_p2_x(out_p[3]), .out_p2_y(out_p[4]), .out_p2_z(out_p[5]),
    .out_status(out_status)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic wide_t round_div(wide_t x, wide_t d);
    wide_t ax, ad, q;
    ax = x[255] ? -x : x;
    ad = d[255] ? -d : d;
    q = (2 * ax + ad) / (2 * ad);
    return (x[255] ^ d[255]) ? -q : q;
  endfunction

  function automatic skl_pkg::ov_t clamp_out(wide_t v, inout logic sat);
    wide_t hi, lo;
    hi = wide_t'(skl_pkg::OMAX);
    lo = wide_t'(skl_pkg::OMIN);
    if (v > hi) begin
      sat = 1'b1;
      return skl_pkg::OMAX;
    end
    if (v < lo) begin
      sat = 1'b1;
      return skl_pkg::OMIN;
    end
    return skl_pkg::ov_t'(v);
  endfunction

  function automatic closest_t closest_points(line_pair_t lp);
    wide_t a[3], c[3], d1[3], d2[3], w[3], n[3], n1[3], n2[3];
    wide_t num1, den1, num2, den2;
    closest_t r;
    logic sat;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a[i] = wide_t'(lp.v[i]);
      c[i] = wide_t'(lp.v[6+i]);
      d1[i] = wide_t'(lp.v[3+i]) - a[i];
      d2[i] = wide_t'(lp.v[9+i]) - c[i];
      w[i] = a[i] - c[i];
    end
    n[0] = d1[1] * d2[2] - d1[2] * d2[1];
    n[1] = d1[2] * d2[0] - d1[0] * d2[2];
    n[2] = d1[0] * d2[1] - d1[1] * d2[0];
    n1[0] = d1[1] * n[2] - d1[2] * n[1];
    n1[1] = d1[2] * n[0] - d1[0] * n[2];
    n1[2] = d1[0] * n[1] - d1[1] * n[0];
    n2[0] = d2[1] * n[2] - d2[2] * n[1];
    n2[1] = d2[2] * n[0] - d2[0] * n[2];
    n2[2] = d2[0] * n[1] - d2[1] * n[0];
    num1 = w[0] * n2[0] + w[1] * n2[1] + w[2] * n2[2];
    den1 = d1[0] * n2[0] + d1[1] * n2[1] + d1[2] * n2[2];
    num2 = -(w[0] * n1[0] + w[1] * n1[1] + w[2] * n1[2]);
    den2 = d2[0] * n1[0] + d2[1] * n1[1] + d2[2] * n1[2];
    if (den1 == 0 || den2 == 0) begin
      for (int i = 0; i < 3; i++) begin
        r.p[i] = clamp_out(a[i], sat);
        r.p[3+i] = clamp_out(c[i], sat);
      end
      r.st = skl_pkg::ST_DEG;
    end else begin
      for (int i = 0; i < 3; i++) begin
        r.p[i] = clamp_out(a[i] - round_div(d1[i] * num1, den1), sat);
        r.p[3+i] = clamp_out(c[i] - round_div(d2[i] * num2, den2), sat);
      end
      r.st = sat ? skl_pkg::ST_SAT : skl_pkg::ST_OK;
    end
    return r;
  endfunction

  // request driver
  always @(posedge clk) begin
    logic accept;
    logic idle;
    accept = rst_n && start && !busy;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (accept) begin
        closest_q.push_back(closest_points(cur_pair));
        sent_cnt <= sent_cnt + 1;
      end
      if (!start || accept) begin
        idle = (sent_cnt < 400 || sent_cnt > 800) && ($urandom_range(99) < 34);
        if (pending_pairs.size() == 0 || idle ||
            (pending_pairs[0].drain && (closest_q.size() != 0 || accept))) begin
          start <= 1'b0;
        end else begin
          cur_pair <= pending_pairs[0];
          for (int i = 0; i < 12; i++) in_v[i] <= pending_pairs[0].v[i];
          void'(pending_pairs.pop_front());
          start <= 1'b1;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    closest_t exp_r;
    logic bad;
    if (rst_n && out_valid) begin
      if (closest_q.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10) $display("unexpected result at %0t", $realtime);
      end else begin
        exp_r = closest_q.pop_front();
        bad = (exp_r.st != out_status);
        for (int i = 0; i < 6; i++) if (exp_r.p[i] != out_p[i]) bad = 1'b1;
        if (bad) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display({"mismatch: exp p=%0d %0d %0d / %0d %0d %0d st=%0d, ",
                      "got %0d %0d %0d / %0d %0d %0d st=%0d"},
              $signed(exp_r.p[0]), $signed(exp_r.p[1]), $signed(exp_r.p[2]),
              $signed(exp_r.p[3]), $signed(exp_r.p[4]), $signed(exp_r.p[5]), exp_r.st,
              out_p[0], out_p[1], out_p[2], out_p[3], out_p[4], out_p[5], out_status);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt > 5000) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic skl_pkg::crd_t rnd_full();
    return skl_pkg::crd_t'($urandom);
  endfunction

  function automatic skl_pkg::crd_t rnd_span(int span);
    return skl_pkg::crd_t'($urandom_range(2 * span) - span);
  endfunction

  task automatic add_pair(skl_pkg::crd_t v[12], logic drain);
    line_pair_t lp;
    lp.drain = drain;
    for (int i = 0; i < 12; i++) lp.v[i] = v[i];
    pending_pairs.push_back(lp);
  endtask

  task automatic add_coords(int a0, int a1, int a2, int b0, int b1, int b2,
                            int c0, int c1, int c2, int d0, int d1, int d2);
    skl_pkg::crd_t v[12];
    v = '{skl_pkg::crd_t'(a0), skl_pkg::crd_t'(a1), skl_pkg::crd_t'(a2),
          skl_pkg::crd_t'(b0), skl_pkg::crd_t'(b1), skl_pkg::crd_t'(b2),
          skl_pkg::crd_t'(c0), skl_pkg::crd_t'(c1), skl_pkg::crd_t'(c2),
          skl_pkg::crd_t'(d0), skl_pkg::crd_t'(d1), skl_pkg::crd_t'(d2)};
    add_pair(v, 1'b0);
  endtask

  initial begin
    skl_pkg::crd_t v[12];
    int kind, span, k;
    int mx, mn;
    rst_n = 1'b0;
    start = 1'b0;
    for (int i = 0; i < 12; i++) in_v[i] = '0;
    cur_pair = '0;
    sent_cnt = 0;
    mismatch_cnt = 0;
    stall_cnt = 0;
    mx = 8388607;
    mn = -8388608;

    // directed: extremes, skew, parallel, degenerate, saturation
    add_coords(0, 0, 0, 256, 0, 0, 0, 256, 256, 0, 256, 512);
    add_coords(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx);
    add_coords(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn);
    add_coords(mn, 0, 0, mx, 0, 0, 0, mn, mx, 0, mx, mn);
    add_coords(mx, mn, mx, mn, mx, mn, mn, mn, mx, mx, mx, mn);
    add_coords(0, 0, 0, mx, mn, mx, mn, mx, mn, mx, mx, mx);
    add_coords(0, 0, 0, 256, 256, 0, 0, 0, 512, 512, 512, 512);
    add_coords(10, 20, 30, 10, 20, 30, 0, 0, 0, 1, 2, 3);
    add_coords(0, 0, 0, 1, 2, 3, 5, 5, 5, 5, 5, 5);
    add_coords(7, 7, 7, 7, 7, 7, -3, 4, 9, -3, 4, 9);
    add_coords(mx, mx, mx, mx, mx, mx, mn, mn, mn, mn, mn, mn);
    add_coords(0, 0, 0, 1, 0, 0, 0, 0, mx, mx, 1, mx);
    add_coords(mn, mn, 0, mn + 1, mn, 0, mx, mx, 100, mx - 1, mx + 0, 100);
    add_coords(0, 0, 0, 1, 0, 0, 0, mx, 0, mx, mx, 1);
    add_coords(mx, 0, 0, mx - 1, 1, 0, mn, 0, mx, mn + 1, 1, mx);
    add_coords(1, -1, 1, -1, 1, -1, 3, 3, -3, -3, -3, 3);
    add_coords(0, 0, 0, 3, 0, 0, 1, 1, 0, 1, 1, 2);
    add_coords(0, 0, 0, 2, 0, 0, -1, 1, 1, -1, 3, -1);

    for (int n = 0; n < 1350; n++) begin
      kind = $urandom_range(9);
      span = ($urandom_range(3) == 0) ? 8388607 : (1 << $urandom_range(20, 2));
      for (int i = 0; i < 12; i++) v[i] = (kind < 3) ? rnd_full() : rnd_span(span);
      if (kind == 5) begin
        // parallel: second direction a multiple of the first
        k = $urandom_range(4) - 2;
        for (int i = 0; i < 3; i++) begin
          v[3+i] = rnd_span(1000);
          v[i] = rnd_span(1000);
          v[9+i] = v[6+i] + k * (v[3+i] - v[i]);
        end
      end else if (kind == 6) begin
        // degenerate: per axis, b copies a or d copies c, so a point pair may coincide
        for (int i = 0; i < 3; i++) begin
          if ($urandom_range(1)) v[3+i] = v[i];
          else v[9+i] = v[6+i];
        end
      end else if (kind == 7) begin
        // nearly parallel, closest points far away
        for (int i = 0; i < 3; i++) begin
          v[i] = rnd_full();
          v[3+i] = v[i] + rnd_span(4096);
          v[6+i] = rnd_full();
          v[9+i] = v[6+i] + (v[3+i] - v[i]) + rnd_span(1);
        end
      end
      add_pair(v, (n == 500 || n == 1000));
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_pairs.size() != 0 || start || closest_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_cnt == 0 && closest_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
src/skl_pkg.sv
src/skl_wmul.sv
src/skl_front.sv
src/skl_scale.sv
src/skl_div.sv
src/skew_line_closest_points_core.sv
tb/testbench.sv
